// ----- design/nat_mapping_table_with_aging_macros.svh -----
// Assertion macros for the NAT mapping table.
// Each macro takes a label, an antecedent and a consequent; clock is clk,
// reset is arst_n.
`ifndef NAT_MAPPING_TABLE_WITH_AGING_MACROS_SVH
`define NAT_MAPPING_TABLE_WITH_AGING_MACROS_SVH
`ifndef SYNTHESIS
`define NMT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nat table assertion failed");
`define NMT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nat table assertion failed");
`else
`define NMT_ASSERT_SAME(lbl, ante, cons)
`define NMT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/nmt_pkg.sv -----
// ----------------------------------------------------------------------------
// nmt_pkg
// Types and constants shared by the NAT mapping table modules.
// ----------------------------------------------------------------------------
package nmt_pkg;

	localparam logic [1:0] OP_INSERT    = 2'd0;
	localparam logic [1:0] OP_LOOKUP_IN = 2'd1;
	localparam logic [1:0] OP_LOOKUP_EX = 2'd2;
	localparam logic [1:0] OP_TICK      = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic KIND_ICMP = 1'b0;
	localparam logic KIND_TCP  = 1'b1;

	localparam logic CFG_EXT_ADDR = 1'b0;
	localparam logic CFG_TIMEOUT  = 1'b1;

	localparam logic [15:0] TCP_PORT_START = 16'd1024;
	localparam logic [15:0] TIMEOUT_RESET  = 16'd60;

	typedef struct packed {
		logic [1:0]  opcode;
		logic        map_kind;
		logic [31:0] inside_address;
		logic [15:0] inside_port;
		logic [15:0] outside_port;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found_kind;
		logic [31:0] found_inside_address;
		logic [15:0] found_inside_port;
		logic [31:0] found_outside_address;
		logic [15:0] found_outside_port;
		logic [31:0] found_stamp;
		logic [6:0]  removed_count;
	} out_item_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] inside_address;
		logic [15:0] inside_port;
		logic [15:0] outside_port;
		logic [31:0] stamp;
	} entry_t;

	typedef struct packed {
		logic load;
		logic insert;
		logic scan;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_done;
	} dp_sts_t;

endpackage

// ----- design/nmt_datapath.sv -----
// ----------------------------------------------------------------------------
// nmt_datapath
// Entry memory kept as a ring (head = newest), counters, clock and the
// result register. Lookups and aging scan one entry per cycle.
// ----------------------------------------------------------------------------
`include "nat_mapping_table_with_aging_macros.svh"

module nmt_datapath #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  nmt_pkg::ctl_cmd_t  cmd,
	output nmt_pkg::dp_sts_t   sts,
	input  nmt_pkg::in_item_t  in_data,
	input  logic               cfg_wr_en,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	output nmt_pkg::out_item_t res
);

	localparam int PW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [PW-1:0] LAST = PW'(TABLE_ENTRIES - 1);
	localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

	nmt_pkg::entry_t mem [TABLE_ENTRIES];
	nmt_pkg::entry_t rd_q;
	nmt_pkg::in_item_t item_q;
	nmt_pkg::out_item_t res_q;

	logic [31:0]   ext_addr_q;
	logic [15:0]   tmo_q;
	logic [31:0]   time_q;
	logic [15:0]   tcp_q;
	logic [15:0]   icmp_q;
	logic [PW-1:0] head_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW-1:0] wr_ptr_q;
	logic [CW-1:0] rd_idx_q;
	logic [CW-1:0] kept_q;
	logic [CW-1:0] removed_q;
	logic          pend_q;

	logic            mem_we;
	logic [PW-1:0]   mem_wa;
	nmt_pkg::entry_t mem_wd;
	logic            mem_re;
	logic [PW-1:0]   head_prev;
	logic            is_lookup;
	logic            hit;
	logic            expire;
	logic            evaluate;
	logic [31:0]     age;
	nmt_pkg::entry_t new_entry;

	assign head_prev = (head_q == '0) ? LAST : head_q - PW'(1);
	assign is_lookup = (item_q.opcode == nmt_pkg::OP_LOOKUP_IN) ||
		(item_q.opcode == nmt_pkg::OP_LOOKUP_EX);
	assign age = time_q - rd_q.stamp;
	assign expire = (rd_q.kind == nmt_pkg::KIND_ICMP) && (age > {16'd0, tmo_q});
	assign evaluate = cmd.scan && pend_q;
	assign mem_re = cmd.scan && (rd_idx_q < cnt_q);

	always_comb begin
		hit = pend_q && (rd_q.kind == item_q.map_kind);
		if (item_q.opcode == nmt_pkg::OP_LOOKUP_IN) begin
			hit = hit && (rd_q.inside_address == item_q.inside_address) &&
				(rd_q.inside_port == item_q.inside_port);
		end else begin
			hit = hit && (rd_q.outside_port == item_q.outside_port);
		end
	end

	assign sts.scan_done = (is_lookup && hit) || (!pend_q && rd_idx_q == cnt_q);

	always_comb begin
		new_entry.kind = item_q.map_kind;
		new_entry.inside_address = item_q.inside_address;
		new_entry.inside_port = item_q.inside_port;
		new_entry.outside_port = item_q.map_kind ? tcp_q : icmp_q;
		new_entry.stamp = time_q;
		mem_we = 1'b0;
		mem_wa = head_prev;
		mem_wd = new_entry;
		if (cmd.insert && cnt_q != FULL) begin
			mem_we = 1'b1;
		end else if (evaluate && !is_lookup && !expire) begin
			mem_we = 1'b1;
			mem_wa = wr_ptr_q;
			mem_wd = rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_addr_q <= '0;
			tmo_q <= nmt_pkg::TIMEOUT_RESET;
			time_q <= '0;
			tcp_q <= nmt_pkg::TCP_PORT_START;
			icmp_q <= '0;
			head_q <= '0;
			cnt_q <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			rd_idx_q <= '0;
			kept_q <= '0;
			removed_q <= '0;
			pend_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == nmt_pkg::CFG_EXT_ADDR) begin
					ext_addr_q <= cfg_data;
				end else begin
					tmo_q <= cfg_data[15:0];
				end
			end
			if (cmd.load) begin
				if (in_data.opcode == nmt_pkg::OP_TICK) begin
					time_q <= time_q + 32'd1;
				end
				rd_ptr_q <= head_q;
				wr_ptr_q <= head_q;
				rd_idx_q <= '0;
				kept_q <= '0;
				removed_q <= '0;
				pend_q <= 1'b0;
			end
			if (cmd.scan) begin
				pend_q <= mem_re;
				if (mem_re) begin
					rd_idx_q <= rd_idx_q + CW'(1);
					rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
				end
				if (evaluate && !is_lookup) begin
					if (expire) begin
						removed_q <= removed_q + CW'(1);
					end else begin
						kept_q <= kept_q + CW'(1);
						wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
					end
				end
			end
			if (cmd.insert) begin
				if (cnt_q == FULL) begin
					res_q <= '{nmt_pkg::ST_FULL, 1'b0, 32'd0, 16'd0, 32'd0, 16'd0,
						32'd0, 7'd0};
				end else begin
					head_q <= head_prev;
					cnt_q <= cnt_q + CW'(1);
					if (item_q.map_kind) begin
						tcp_q <= tcp_q + 16'd1;
					end else begin
						icmp_q <= icmp_q + 16'd1;
					end
					res_q <= '{nmt_pkg::ST_OK, new_entry.kind, new_entry.inside_address,
						new_entry.inside_port, ext_addr_q, new_entry.outside_port,
						new_entry.stamp, 7'd0};
				end
			end
			if (cmd.finish) begin
				if (!is_lookup) begin
					cnt_q <= kept_q;
					res_q <= '{nmt_pkg::ST_OK, 1'b0, 32'd0, 16'd0, 32'd0, 16'd0, 32'd0,
						(32'(removed_q) > 32'd127) ? 7'd127 : 7'(removed_q)};
				end else if (hit) begin
					res_q <= '{nmt_pkg::ST_OK, rd_q.kind, rd_q.inside_address,
						rd_q.inside_port, ext_addr_q, rd_q.outside_port, rd_q.stamp, 7'd0};
				end else begin
					res_q <= '{nmt_pkg::ST_MISS, 1'b0, 32'd0, 16'd0, 32'd0, 16'd0,
						32'd0, 7'd0};
				end
			end
		end
	end

	assign res = res_q;

	`NMT_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= FULL)
	`NMT_ASSERT_SAME(a_scan_tally, 1'b1, ({1'b0, kept_q} + {1'b0, removed_q}) <= {1'b0, rd_idx_q})
	`NMT_ASSERT_SAME(a_pend_issued, pend_q, rd_idx_q != '0)

endmodule

// ----- design/nmt_ctrl.sv -----
// ----------------------------------------------------------------------------
// nmt_ctrl
// Sequencer: takes an item, runs insert or scan, hands the result to the
// output register once it is free.
// ----------------------------------------------------------------------------
`include "nat_mapping_table_with_aging_macros.svh"

module nmt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        opcode,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output nmt_pkg::ctl_cmd_t cmd,
	input  nmt_pkg::dp_sts_t  sts
);

	typedef enum logic [1:0] {
		IDLE,
		INSERT,
		SCAN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load = in_valid && (state_q == IDLE);
		cmd.insert = (state_q == INSERT) && out_free;
		cmd.scan = (state_q == SCAN) && !sts.scan_done;
		cmd.finish = (state_q == SCAN) && sts.scan_done && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.insert || cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						state_q <= (opcode == nmt_pkg::OP_INSERT) ? INSERT : SCAN;
					end
				end
				INSERT: begin
					if (cmd.insert) begin
						state_q <= IDLE;
					end
				end
				SCAN: begin
					if (cmd.finish) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	`NMT_ASSERT_SAME(a_insert_free, cmd.insert, !out_valid_q || !out_stall)
	`NMT_ASSERT_SAME(a_finish_done, cmd.finish, sts.scan_done)
	`NMT_ASSERT_NEXT(a_result_shown, cmd.insert || cmd.finish, out_valid_q)

endmodule

// ----- design/nat_mapping_table_with_aging.sv -----
// Insert needs no scan; lookup and tick scan the live entries (hit stops a lookup
// early), one entry per cycle through the single read port of the entry memory.
// One item in work at a time; the result register frees the output side.
// Reset (arst_n, async) empties the table, time 0, TCP id 1024, ICMP id 0,
// timeout 60, external address 0; no clearing pass.
// ----------------------------------------------------------------------------
// nat_mapping_table_with_aging
// NAT mapping table, newest first, with ICMP aging on each one-second tick.
// ----------------------------------------------------------------------------
module nat_mapping_table_with_aging #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  nmt_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output nmt_pkg::out_item_t out_data,
	input  logic               cfg_wr_en,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data
);

	nmt_pkg::ctl_cmd_t cmd;
	nmt_pkg::dp_sts_t  sts;

	nmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.opcode    (in_data.opcode),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	nmt_datapath #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res       (out_data)
	);

endmodule
